/* design/bdq_pkg.sv */
// ----------------------------------------------------------------------------
// bdq_pkg: shared types and constants for the bounded deque with search
// Holds the store geometry, operation and status codes, the record and
// result structures, the memory request bundle and the sequencer states.
// ----------------------------------------------------------------------------
package bdq_pkg;

  // store geometry (DEPTH must be a power of two: slots wrap by truncation)
  localparam int unsigned DEPTH        = 16;
  localparam int unsigned ADDR_W       = $clog2(DEPTH);
  localparam int unsigned CNT_W        = $clog2(DEPTH + 1);

  // record fields
  localparam int unsigned KEY_BITS     = 64;
  localparam int unsigned PAYLOAD_BITS = 32;
  localparam int unsigned REC_W        = KEY_BITS + PAYLOAD_BITS;

  // stream fields
  localparam int unsigned MODE_W       = 3;
  localparam int unsigned POS_W        = 8;
  localparam int unsigned STAT_W       = 3;
  localparam int unsigned IN_RAW_W     = POS_W + KEY_BITS + PAYLOAD_BITS;
  localparam int unsigned IN_DATA_W    = ((IN_RAW_W + 7) / 8) * 8;
  localparam int unsigned OUT_RAW_W    = KEY_BITS + PAYLOAD_BITS + ADDR_W + CNT_W;
  localparam int unsigned OUT_DATA_W   = ((OUT_RAW_W + 7) / 8) * 8;

  // operation codes
  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH_FRONT = 3'd0,
    MODE_PUSH_BACK  = 3'd1,
    MODE_POP_FRONT  = 3'd2,
    MODE_POP_BACK   = 3'd3,
    MODE_READ       = 3'd4,
    MODE_FIND       = 3'd5,
    MODE_DELETE     = 3'd6
  } mode_e;

  // status codes
  typedef enum logic [STAT_W-1:0] {
    STAT_OK        = 3'd0,
    STAT_EMPTY     = 3'd1,
    STAT_RANGE     = 3'd2,
    STAT_NOT_FOUND = 3'd3,
    STAT_FULL      = 3'd4
  } stat_e;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RD_WAIT,
    ST_FIND,
    ST_DEL_FIRST,
    ST_DEL_SHIFT,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [PAYLOAD_BITS-1:0] payload;
    logic [KEY_BITS-1:0]     key;
  } rec_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    rec_t              wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

  typedef struct packed {
    stat_e                   status;
    logic [KEY_BITS-1:0]     key;
    logic [PAYLOAD_BITS-1:0] payload;
    logic [ADDR_W-1:0]       index;
    logic [CNT_W-1:0]        held;
  } res_t;

  // ring slot of a position counted from the front
  function automatic logic [ADDR_W-1:0] slot_of(input logic [ADDR_W-1:0] front,
                                                input logic [CNT_W-1:0]  off);
    return front + off[ADDR_W-1:0];
  endfunction

endpackage

/* design/bdq_ram.sv */
// ----------------------------------------------------------------------------
// bdq_ram: record store
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module bdq_ram (
  input  logic            clk_i,
  input  bdq_pkg::ram_req_t req_i,
  output bdq_pkg::rec_t   rdata_o
);
  import bdq_pkg::*;

  rec_t mem_q [DEPTH];
  rec_t rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* design/bdq_ctrl.sv */
// ----------------------------------------------------------------------------
// bdq_ctrl: operation sequencer
// Holds front slot and entry count, decodes one operation at a time and
// walks the record store for find and for the gap closing of delete.
// ----------------------------------------------------------------------------
module bdq_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // operation transfer
  input  logic                         op_valid_i,
  output logic                         op_ready_o,
  input  bdq_pkg::mode_e               op_mode_i,
  input  logic [bdq_pkg::POS_W-1:0]    op_pos_i,
  input  logic [bdq_pkg::KEY_BITS-1:0] op_key_i,
  input  logic [bdq_pkg::PAYLOAD_BITS-1:0] op_payload_i,
  // result hand-off
  output logic                         res_valid_o,
  input  logic                         res_ready_i,
  output bdq_pkg::res_t                res_o,
  // record store
  output bdq_pkg::ram_req_t            ram_req_o,
  input  bdq_pkg::rec_t                ram_rdata_i
);
  import bdq_pkg::*;

  state_e                  state_q, state_d;
  logic [ADDR_W-1:0]       front_q, front_d;
  logic [CNT_W-1:0]        count_q, count_d;
  logic [CNT_W-1:0]        idx_q, idx_d;
  mode_e                   mode_q, mode_d;
  logic [POS_W-1:0]        pos_q, pos_d;
  logic [KEY_BITS-1:0]     key_q, key_d;
  logic [PAYLOAD_BITS-1:0] pay_q, pay_d;
  res_t                    res_q, res_d;

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      front_q <= '0;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      front_q <= front_d;
      count_q <= count_d;
    end
  end

  // operation and result payload
  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    mode_q <= mode_d;
    pos_q  <= pos_d;
    key_q  <= key_d;
    pay_q  <= pay_d;
    res_q  <= res_d;
  end

  // next state, store requests and result
  always_comb begin
    state_d   = state_q;
    front_d   = front_q;
    count_d   = count_q;
    idx_d     = idx_q;
    mode_d    = mode_q;
    pos_d     = pos_q;
    key_d     = key_q;
    pay_d     = pay_q;
    res_d     = res_q;
    ram_req_o = '0;
    op_ready_o  = 1'b0;
    res_valid_o = 1'b0;

    case (state_q)
      // wait for an operation
      ST_IDLE: begin
        op_ready_o = 1'b1;
        if (op_valid_i) begin
          mode_d         = op_mode_i;
          pos_d          = op_pos_i;
          key_d          = op_key_i;
          pay_d          = op_payload_i;
          res_d          = '0;
          res_d.status   = STAT_OK;
          state_d        = ST_EXEC;
        end
      end

      // decode and start the operation
      ST_EXEC: begin
        state_d = ST_DONE;
        case (mode_q)
          MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
            if (count_q == CNT_W'(DEPTH)) begin
              res_d.status = STAT_FULL;
            end else begin
              ram_req_o.we            = 1'b1;
              ram_req_o.wdata.key     = key_q;
              ram_req_o.wdata.payload = pay_q;
              if (mode_q == MODE_PUSH_FRONT) begin
                front_d         = front_q - ADDR_W'(1);
                ram_req_o.waddr = front_q - ADDR_W'(1);
              end else begin
                ram_req_o.waddr = slot_of(front_q, count_q);
              end
              count_d = count_q + CNT_W'(1);
            end
          end
          MODE_POP_FRONT, MODE_POP_BACK: begin
            if (count_q == '0) begin
              res_d.status = STAT_EMPTY;
            end else begin
              ram_req_o.re = 1'b1;
              if (mode_q == MODE_POP_FRONT) begin
                ram_req_o.raddr = front_q;
                front_d         = front_q + ADDR_W'(1);
              end else begin
                ram_req_o.raddr = slot_of(front_q, count_q - CNT_W'(1));
              end
              count_d = count_q - CNT_W'(1);
              state_d = ST_RD_WAIT;
            end
          end
          MODE_READ: begin
            if (pos_q >= POS_W'(count_q)) begin
              res_d.status = STAT_RANGE;
            end else begin
              ram_req_o.re    = 1'b1;
              ram_req_o.raddr = slot_of(front_q, pos_q[CNT_W-1:0]);
              state_d         = ST_RD_WAIT;
            end
          end
          MODE_FIND: begin
            if (count_q == '0) begin
              res_d.status = STAT_NOT_FOUND;
            end else begin
              ram_req_o.re    = 1'b1;
              ram_req_o.raddr = front_q;
              idx_d           = '0;
              state_d         = ST_FIND;
            end
          end
          MODE_DELETE: begin
            if (pos_q >= POS_W'(count_q)) begin
              res_d.status = STAT_RANGE;
            end else begin
              ram_req_o.re    = 1'b1;
              ram_req_o.raddr = slot_of(front_q, pos_q[CNT_W-1:0]);
              idx_d           = pos_q[CNT_W-1:0];
              state_d         = ST_DEL_FIRST;
            end
          end
          default: begin
            // unused code: no change, ok status
            res_d.status = STAT_OK;
          end
        endcase
      end

      // capture the record of a pop or read
      ST_RD_WAIT: begin
        res_d.key     = ram_rdata_i.key;
        res_d.payload = ram_rdata_i.payload;
        state_d       = ST_DONE;
      end

      // compare one held entry per cycle, front first
      ST_FIND: begin
        if (ram_rdata_i.key == key_q) begin
          res_d.status  = STAT_OK;
          res_d.key     = ram_rdata_i.key;
          res_d.payload = ram_rdata_i.payload;
          res_d.index   = idx_q[ADDR_W-1:0];
          state_d       = ST_DONE;
        end else if (idx_q + CNT_W'(1) == count_q) begin
          res_d.status = STAT_NOT_FOUND;
          state_d      = ST_DONE;
        end else begin
          ram_req_o.re    = 1'b1;
          ram_req_o.raddr = slot_of(front_q, idx_q + CNT_W'(1));
          idx_d           = idx_q + CNT_W'(1);
        end
      end

      // capture the deleted record, start closing the gap
      ST_DEL_FIRST: begin
        res_d.key     = ram_rdata_i.key;
        res_d.payload = ram_rdata_i.payload;
        if (idx_q + CNT_W'(1) < count_q) begin
          ram_req_o.re    = 1'b1;
          ram_req_o.raddr = slot_of(front_q, idx_q + CNT_W'(1));
          state_d         = ST_DEL_SHIFT;
        end else begin
          count_d = count_q - CNT_W'(1);
          state_d = ST_DONE;
        end
      end

      // move entry idx+1 into slot of idx, prefetch idx+2
      ST_DEL_SHIFT: begin
        ram_req_o.we    = 1'b1;
        ram_req_o.waddr = slot_of(front_q, idx_q);
        ram_req_o.wdata = ram_rdata_i;
        idx_d           = idx_q + CNT_W'(1);
        if (idx_q + CNT_W'(2) < count_q) begin
          ram_req_o.re    = 1'b1;
          ram_req_o.raddr = slot_of(front_q, idx_q + CNT_W'(2));
        end else begin
          count_d = count_q - CNT_W'(1);
          state_d = ST_DONE;
        end
      end

      // hand the result to the output register
      ST_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // result with the entry count after the operation
  always_comb begin
    res_o      = res_q;
    res_o.held = count_q;
  end

endmodule

/* design/bounded_deque_with_search.sv */
// ----------------------------------------------------------------------------
// bounded_deque_with_search: bounded double-ended queue of keyed records
// Ring buffer of records with push, pop, read, find and delete at a position.
// ----------------------------------------------------------------------------
// Usage
//   s_axis carries one operation per transfer: tuser holds the mode, tdata the
//   position, key and payload. m_axis returns exactly one result per
//   operation: tuser holds the status, tdata the record found, its index and
//   the entry count after the operation.
//   Operations are done one at a time by a sequencer around a record memory
//   with registered read data. After accept, every operation is decoded;
//   push, refused operations and unused modes then go straight to the result;
//   pop and read wait for the read data; find compares entries from the front
//   one at a time until a match or the last entry (up to 16 compared);
//   delete captures the record, then moves each later entry toward the front.
//   The next operation is accepted in the cycle after the result leaves the
//   sequencer; the memory walk of find and delete makes those the longest.
//   Reset empties the queue at once; memory contents are not cleared.
//   A stalled result waits in the output register; one more operation can
//   be accepted and worked on meanwhile, and then input stalls.
// ----------------------------------------------------------------------------
module bounded_deque_with_search (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // operation input
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // tdata: position [7:0], record_key [71:8], record_payload [103:72]
  input  logic [bdq_pkg::IN_DATA_W-1:0]     s_axis_tdata_i,
  // tuser: mode [2:0]
  input  logic [bdq_pkg::MODE_W-1:0]        s_axis_tuser_i,
  // result output
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // tdata: found_key [63:0], found_payload [95:64], found_index [99:96],
  //        entries_held [104:100], zero fill above
  output logic [bdq_pkg::OUT_DATA_W-1:0]    m_axis_tdata_o,
  // tuser: status [2:0]
  output logic [bdq_pkg::STAT_W-1:0]        m_axis_tuser_o
);
  import bdq_pkg::*;

  ram_req_t ram_req;
  rec_t     ram_rdata;
  logic     res_valid;
  logic     res_ready;
  res_t     res;
  logic     out_valid_q;
  res_t     out_res_q;

  // sequencer
  bdq_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .op_valid_i   (s_axis_tvalid_i),
    .op_ready_o   (s_axis_tready_o),
    .op_mode_i    (mode_e'(s_axis_tuser_i)),
    .op_pos_i     (s_axis_tdata_i[POS_W-1:0]),
    .op_key_i     (s_axis_tdata_i[POS_W+KEY_BITS-1:POS_W]),
    .op_payload_i (s_axis_tdata_i[IN_RAW_W-1:POS_W+KEY_BITS]),
    .res_valid_o  (res_valid),
    .res_ready_i  (res_ready),
    .res_o        (res),
    .ram_req_o    (ram_req),
    .ram_rdata_i  (ram_rdata)
  );

  // record store
  bdq_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (ram_rdata)
  );

  // output register
  assign res_ready = !out_valid_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_res_q <= res;
    end
  end

  // result packing
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_res_q.status;
  assign m_axis_tdata_o  = {{(OUT_DATA_W - OUT_RAW_W){1'b0}}, out_res_q.held,
                            out_res_q.index, out_res_q.payload, out_res_q.key};

endmodule

/* design/bdq_checker.sv */
// ----------------------------------------------------------------------------
// bdq_checker: port level checks for the bounded deque
// Watches the result channel for stalls and for status and count coherence.
// ----------------------------------------------------------------------------
module bdq_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           m_axis_tvalid_o,
  input logic                           m_axis_tready_i,
  input logic [bdq_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,
  input logic [bdq_pkg::STAT_W-1:0]     m_axis_tuser_o
);
  import bdq_pkg::*;

  localparam int unsigned HeldLo = KEY_BITS + PAYLOAD_BITS + ADDR_W;

  logic [CNT_W-1:0]            held;
  logic [KEY_BITS-1:0]         f_key;
  logic [PAYLOAD_BITS-1:0]     f_pay;

  assign held  = m_axis_tdata_o[HeldLo+CNT_W-1:HeldLo];
  assign f_key = m_axis_tdata_o[KEY_BITS-1:0];
  assign f_pay = m_axis_tdata_o[KEY_BITS+PAYLOAD_BITS-1:KEY_BITS];

  // a stalled result keeps its status
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tuser_o))
    else $error("result changed while stalled");

  // full is reported only with a full store
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == STAT_FULL |-> held == CNT_W'(DEPTH))
    else $error("full status with spare room");

  // empty is reported only with an empty store
  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == STAT_EMPTY |-> held == '0)
    else $error("empty status with entries held");

  // count never exceeds the store
  a_held_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> held <= CNT_W'(DEPTH))
    else $error("entry count beyond depth");

  // failed operations return no record
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o != STAT_OK |-> f_key == '0 && f_pay == '0)
    else $error("record returned with failing status");

endmodule

bind bounded_deque_with_search bdq_checker u_bdq_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);
